// ===== sv/gbrw_pkg.sv =====
package gbrw_pkg;

  localparam int MAX_STEPS_DEF   = 64;
  localparam int BLOCK_SHIFT_DEF = 23;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int COORD_W = 32;
  localparam int BLK_W   = 9;

  localparam logic [0:0] REG_ORIGIN_X = 1'b0;
  localparam logic [0:0] REG_ORIGIN_Y = 1'b1;

  // One set-up trace handed from the front to the walker.
  typedef struct packed {
    logic [31:0] mapx;
    logic [31:0] mapy;
    logic [31:0] xt2;
    logic [31:0] yt2;
    logic [1:0]  sx;
    logic [1:0]  sy;
    logic [31:0] xint;
    logic [31:0] yint;
    logic [31:0] xstep;
    logic [31:0] ystep;
  } walk_t;

endpackage

// ===== sv/gbrw_div.sv =====
module gbrw_div #(
  parameter int FRAC_BITS = gbrw_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [31:0] a,
  input  logic [31:0] bmag,
  output logic        done,
  output logic [31:0] q
);

  localparam int NW = 32 + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] num_r, num_nxt;
  logic [32:0]   rem_r, rem_nxt;
  logic [31:0]   den_r, den_nxt;
  logic          neg_r, neg_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [31:0]   q_r, q_nxt;
  logic [31:0]   amag;
  logic [33:0]   trial;
  logic [NW-1:0] qfull;

  assign amag  = a[31] ? (32'd0 - a) : a;
  assign trial = {rem_r, num_r[NW-1]} - {2'b00, den_r};
  assign qfull = neg_r ? ({NW{1'b0}} - num_r) : num_r;

  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    q_nxt    = q_r;
    if (go) begin
      if ((amag >> (30 - FRAC_BITS)) >= bmag) begin
        q_nxt    = a[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        done_nxt = 1'b1;
      end else begin
        num_nxt  = {amag, {FRAC_BITS{1'b0}}};
        rem_nxt  = '0;
        den_nxt  = bmag;
        neg_nxt  = a[31];
        cnt_nxt  = CW'(NW);
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      // Restoring divide, one quotient bit a cycle; quotient shifts into num.
      if (!trial[33]) begin
        rem_nxt = trial[32:0];
        num_nxt = {num_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[31:0], num_r[NW-1]};
        num_nxt = {num_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
    if (!busy_r && !go && cnt_r == '0 && den_r != '0) begin
      q_nxt    = qfull[31:0];
      done_nxt = 1'b1;
      den_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      den_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      den_r  <= den_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

// ===== sv/gbrw_front.sv =====
module gbrw_front #(
  parameter int BLOCK_SHIFT = gbrw_pkg::BLOCK_SHIFT_DEF,
  parameter int FRAC_BITS   = gbrw_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [31:0]         in_start_x,
  input  logic [31:0]         in_start_y,
  input  logic [31:0]         in_end_x,
  input  logic [31:0]         in_end_y,
  input  logic [31:0]         org_x,
  input  logic [31:0]         org_y,
  output gbrw_pkg::walk_t     wk,
  output logic                wk_valid,
  input  logic                wk_ready
);

  localparam int B2F = BLOCK_SHIFT - FRAC_BITS;
  localparam logic [31:0] UNIT  = 32'd1 << FRAC_BITS;
  localparam logic [31:0] BIG   = 32'd256 << FRAC_BITS;
  localparam logic [31:0] BMASK = (32'd1 << BLOCK_SHIFT) - 32'd1;

  typedef enum logic [2:0] {S_IDLE, S_DIVY, S_WAITY, S_DIVX, S_WAITX, S_MULY, S_MULX, S_PUSH}
    state_t;

  state_t      state_r;
  logic [31:0] x1_r, y1_r, x2_r, y2_r, xt1_r, yt1_r, xt2_r, yt2_r;
  logic [1:0]  sx_r, sy_r;
  logic [31:0] xstep_r, ystep_r, xint_r, yint_r;
  logic [63:0] prod_r;

  logic [31:0] sx1, sy1, rx1, ry1, rx2, ry2, dx, dy;
  logic [31:0] xs, ys, xpart, ypart;
  logic        dgo;
  logic [31:0] da, db, dq;
  logic        ddone;
  logic [63:0] mul_p;
  logic [31:0] mul_a, mul_b;

  assign sx1 = ((in_start_x - org_x) & BMASK) == '0 ? in_start_x + UNIT : in_start_x;
  assign sy1 = ((in_start_y - org_y) & BMASK) == '0 ? in_start_y + UNIT : in_start_y;
  assign rx1 = sx1 - org_x;
  assign ry1 = sy1 - org_y;
  assign rx2 = in_end_x - org_x;
  assign ry2 = in_end_y - org_y;

  assign dx = x2_r - x1_r;
  assign dy = y2_r - y1_r;
  assign xs = 32'($signed(x1_r) >>> B2F);
  assign ys = 32'($signed(y1_r) >>> B2F);

  always_comb begin
    case (sx_r)
      2'b01:   xpart = UNIT - (xs & (UNIT - 32'd1));
      2'b11:   xpart = xs & (UNIT - 32'd1);
      default: xpart = UNIT;
    endcase
    case (sy_r)
      2'b01:   ypart = UNIT - (ys & (UNIT - 32'd1));
      2'b11:   ypart = ys & (UNIT - 32'd1);
      default: ypart = UNIT;
    endcase
  end

  assign dgo = (state_r == S_DIVY) || (state_r == S_DIVX);
  assign da  = (state_r == S_DIVY) ? dy : dx;
  assign db  = (state_r == S_DIVY) ? (dx[31] ? 32'd0 - dx : dx)
                                   : (dy[31] ? 32'd0 - dy : dy);

  gbrw_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (dgo),
    .a    (da),
    .bmag (db),
    .done (ddone),
    .q    (dq)
  );

  assign mul_a = (state_r == S_MULY) ? xpart : ypart;
  assign mul_b = (state_r == S_MULY) ? ystep_r : xstep_r;
  assign mul_p = 64'($signed(mul_a) * $signed(mul_b));

  // Hand the finished setup over once xint has settled in the push cycle.
  logic push_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (start) begin
            x1_r  <= rx1;
            y1_r  <= ry1;
            x2_r  <= rx2;
            y2_r  <= ry2;
            xt1_r <= 32'($signed(rx1) >>> BLOCK_SHIFT);
            yt1_r <= 32'($signed(ry1) >>> BLOCK_SHIFT);
            xt2_r <= 32'($signed(rx2) >>> BLOCK_SHIFT);
            yt2_r <= 32'($signed(ry2) >>> BLOCK_SHIFT);
            state_r <= S_DIVY;
          end
        end
        S_DIVY: begin
          if ($signed(xt2_r) > $signed(xt1_r)) sx_r <= 2'b01;
          else if ($signed(xt2_r) < $signed(xt1_r)) sx_r <= 2'b11;
          else sx_r <= 2'b00;
          if ($signed(yt2_r) > $signed(yt1_r)) sy_r <= 2'b01;
          else if ($signed(yt2_r) < $signed(yt1_r)) sy_r <= 2'b11;
          else sy_r <= 2'b00;
          state_r <= S_WAITY;
        end
        S_WAITY: begin
          if (ddone) begin
            ystep_r <= (sx_r == 2'b00) ? BIG : dq;
            state_r <= S_DIVX;
          end
        end
        S_DIVX: state_r <= S_WAITX;
        S_WAITX: begin
          if (ddone) begin
            xstep_r <= (sy_r == 2'b00) ? BIG : dq;
            state_r <= S_MULY;
          end
        end
        S_MULY: begin
          prod_r  <= mul_p;
          state_r <= S_MULX;
        end
        S_MULX: begin
          yint_r  <= ys + 32'($signed(prod_r) >>> FRAC_BITS);
          prod_r  <= mul_p;
          state_r <= S_PUSH;
        end
        S_PUSH: begin
          xint_r <= xs + 32'($signed(prod_r) >>> FRAC_BITS);
          if (wk_ready && !push_r) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      push_r <= 1'b0;
    end else begin
      push_r <= (state_r == S_MULX);
    end
  end

  assign wk_valid = (state_r == S_PUSH) && !push_r;
  assign busy     = (state_r != S_IDLE);
  assign wk.mapx  = xt1_r;
  assign wk.mapy  = yt1_r;
  assign wk.xt2   = xt2_r;
  assign wk.yt2   = yt2_r;
  assign wk.sx    = sx_r;
  assign wk.sy    = sy_r;
  assign wk.xint  = xint_r;
  assign wk.yint  = yint_r;
  assign wk.xstep = xstep_r;
  assign wk.ystep = ystep_r;

endmodule

// ===== sv/gbrw_walk.sv =====
module gbrw_walk #(
  parameter int MAX_STEPS = gbrw_pkg::MAX_STEPS_DEF,
  parameter int FRAC_BITS = gbrw_pkg::FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  gbrw_pkg::walk_t wk,
  input  logic            wk_valid,
  output logic            wk_ready,
  output logic            out_valid,
  output logic [8:0]      out_block_x,
  output logic [8:0]      out_block_y,
  output logic            out_reached_end,
  output logic            out_last
);

  localparam int NW = $clog2(MAX_STEPS + 1);

  gbrw_pkg::walk_t w_r;
  logic            run_r;
  logic [NW-1:0]   n_r;
  logic            at_end, fin;
  logic [31:0]     yi, xi;
  logic            ov_r, oe_r, ol_r;
  logic [8:0]      ox_r, oy_r;

  assign at_end = (w_r.mapx == w_r.xt2) && (w_r.mapy == w_r.yt2);
  assign fin    = at_end || (n_r == NW'(MAX_STEPS - 1));
  assign yi     = 32'($signed(w_r.yint) >>> FRAC_BITS);
  assign xi     = 32'($signed(w_r.xint) >>> FRAC_BITS);
  assign wk_ready = !run_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      ov_r <= run_r;
      if (!run_r) begin
        if (wk_valid) begin
          w_r   <= wk;
          n_r   <= '0;
          run_r <= 1'b1;
        end
      end else begin
        ox_r <= w_r.mapx[8:0];
        oy_r <= w_r.mapy[8:0];
        oe_r <= at_end;
        ol_r <= fin;
        n_r  <= n_r + 1'b1;
        if (fin) begin
          run_r <= 1'b0;
        end else if (yi == w_r.mapy) begin
          w_r.yint <= w_r.yint + w_r.ystep;
          w_r.mapx <= w_r.mapx + {{30{w_r.sx[1]}}, w_r.sx};
        end else if (xi == w_r.mapx) begin
          w_r.xint <= w_r.xint + w_r.xstep;
          w_r.mapy <= w_r.mapy + {{30{w_r.sy[1]}}, w_r.sy};
        end
      end
    end
  end

  assign out_valid       = ov_r;
  assign out_block_x     = ox_r;
  assign out_block_y     = oy_r;
  assign out_reached_end = oe_r;
  assign out_last        = ol_r;

`ifndef SYNTHESIS
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reached_end |-> out_last) else $error("end block not last");
  a_last_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid) else $error("result after last");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> n_r < NW'(MAX_STEPS)) else $error("step count overrun");
`endif

endmodule

// ===== sv/grid_block_ray_walker.sv =====
// Channel   Ports                                   Handshake
// input     in_start_x/y, in_end_x/y                start & !busy
// result    out_block_x/y, out_reached_end, out_last  out_valid, one cycle
// config    cfg_we, cfg_index, cfg_wdata            cfg_we
// Setup runs both step divisions, ystep then xstep, through the shared bit-serial divider.
// The walker then emits one block a cycle, up to MAX_STEPS per item.
// The next item's setup overlaps the current walk through a one-entry hand-off.
// Synchronous active-low reset clears all control state; origins reset to 0.
// The receiver cannot stall; results arrive with out_valid for one cycle each.
module grid_block_ray_walker #(
  parameter int MAX_STEPS   = gbrw_pkg::MAX_STEPS_DEF,
  parameter int BLOCK_SHIFT = gbrw_pkg::BLOCK_SHIFT_DEF,
  parameter int FRAC_BITS   = gbrw_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_start_x,
  input  logic [31:0] in_start_y,
  input  logic [31:0] in_end_x,
  input  logic [31:0] in_end_y,
  output logic        out_valid,
  output logic [8:0]  out_block_x,
  output logic [8:0]  out_block_y,
  output logic        out_reached_end,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  logic [31:0]     org_x_r, org_y_r;
  gbrw_pkg::walk_t wk;
  logic            wk_valid;
  logic            wk_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r <= '0;
      org_y_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == gbrw_pkg::REG_ORIGIN_X) org_x_r <= cfg_wdata;
      if (cfg_index == gbrw_pkg::REG_ORIGIN_Y) org_y_r <= cfg_wdata;
    end
  end

  gbrw_front #(.BLOCK_SHIFT(BLOCK_SHIFT), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_start_x(in_start_x),
    .in_start_y(in_start_y),
    .in_end_x  (in_end_x),
    .in_end_y  (in_end_y),
    .org_x     (org_x_r),
    .org_y     (org_y_r),
    .wk        (wk),
    .wk_valid  (wk_valid),
    .wk_ready  (wk_ready)
  );

  gbrw_walk #(.MAX_STEPS(MAX_STEPS), .FRAC_BITS(FRAC_BITS)) u_walk (
    .clk            (clk),
    .rst_n          (rst_n),
    .wk             (wk),
    .wk_valid       (wk_valid),
    .wk_ready       (wk_ready),
    .out_valid      (out_valid),
    .out_block_x    (out_block_x),
    .out_block_y    (out_block_y),
    .out_reached_end(out_reached_end),
    .out_last       (out_last)
  );

endmodule
